// ===== rtl/core/sfsc_pkg.sv =====
// Shared constants and types for the sampled frame snap capture unit.
package sfsc_pkg;

    localparam int SNAP_BYTES = 64;
    localparam int CNT_W = $clog2(SNAP_BYTES + 1);
    localparam int WORDS = (SNAP_BYTES + 1) / 2;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MEM_DEPTH = 2 * (2 ** WIDX_W);

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [15:0] RATE_RESET = 16'd10;
    localparam logic [CNT_W-1:0] SNAP_COUNT = CNT_W'(SNAP_BYTES);

    localparam logic [1:0] BYTES_ONE = 2'd1;
    localparam logic [1:0] BYTES_TWO = 2'd2;

    // One finished record waiting for the back end.
    typedef struct packed {
        logic [15:0]      len;
        logic [CNT_W-1:0] cnt;
    } sfsc_desc_t;

    // One byte write into the capture store.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [WIDX_W-1:0] widx;
        logic              hi_lane;
        logic [7:0]        data;
    } sfsc_wr_t;

endpackage

// ===== rtl/core/sfsc_front.sv =====
// Front end: sampling countdown, length counting and byte capture.
module sfsc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          frame_byte,
    input  logic                frame_end,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                bank,
    output sfsc_pkg::sfsc_wr_t  wr,
    output logic                desc_push,
    output sfsc_pkg::sfsc_desc_t desc
);
    import sfsc_pkg::*;

    logic [15:0]      rate_reg, rate_next;
    logic [15:0]      countdown_reg, countdown_next;
    logic             mid_frame_reg, mid_frame_next;
    logic             taking_reg, taking_next;
    logic [15:0]      len_reg, len_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             eff_take;
    logic [15:0]      eff_len;
    logic [CNT_W-1:0] eff_cnt;

    always_comb
    begin
        rate_next      = cfg_we ? cfg_wdata : rate_reg;
        countdown_next = countdown_reg;
        mid_frame_next = mid_frame_reg;
        taking_next    = taking_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        eff_take       = taking_reg;
        eff_len        = len_reg;
        eff_cnt        = cnt_reg;
        wr             = '0;
        desc_push      = 1'b0;
        desc.len       = '0;
        desc.cnt       = '0;

        if (accept)
        begin
            if (!mid_frame_reg)
            begin
                if (countdown_reg > 16'd1)
                begin
                    countdown_next = countdown_reg - 16'd1;
                    eff_take       = 1'b0;
                end
                else
                begin
                    countdown_next = rate_reg;
                    eff_take       = 1'b1;
                    eff_len        = '0;
                    eff_cnt        = '0;
                end
            end

            len_next    = eff_len;
            cnt_next    = eff_cnt;
            taking_next = eff_take;

            if (eff_take)
            begin
                if (eff_len != LEN_MAX)
                begin
                    len_next = eff_len + 16'd1;
                end
                if (eff_cnt < SNAP_COUNT)
                begin
                    wr.en      = 1'b1;
                    wr.bank    = bank;
                    wr.widx    = WIDX_W'(eff_cnt >> 1);
                    wr.hi_lane = ~eff_cnt[0];
                    wr.data    = frame_byte;
                    cnt_next   = eff_cnt + CNT_W'(1);
                end
            end

            mid_frame_next = ~frame_end;

            if (frame_end && eff_take)
            begin
                desc_push   = 1'b1;
                desc.len    = len_next;
                desc.cnt    = cnt_next;
                taking_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RESET;
            countdown_reg <= 16'd1;
            mid_frame_reg <= 1'b0;
            taking_reg    <= 1'b0;
            len_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            rate_reg      <= rate_next;
            countdown_reg <= countdown_next;
            mid_frame_reg <= mid_frame_next;
            taking_reg    <= taking_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/sfsc_desc_queue.sv =====
// Two-entry queue of finished record descriptors; each entry owns one store bank.
module sfsc_desc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfsc_pkg::sfsc_desc_t push_desc,
    input  logic                 pop,
    output logic                 full,
    output logic                 wr_bank,
    output logic                 head_valid,
    output logic                 rd_bank,
    output sfsc_pkg::sfsc_desc_t head
);
    import sfsc_pkg::*;

    sfsc_desc_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign wr_bank    = wr_ptr_reg;
    assign rd_bank    = rd_ptr_reg;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/sfsc_back.sv =====
// Back end: capture store and the sequencer that emits record words.
module sfsc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfsc_pkg::sfsc_wr_t   wr,
    input  logic                 head_valid,
    input  logic                 rd_bank,
    input  sfsc_pkg::sfsc_desc_t head,
    output logic                 done,
    output logic                 empty,
    input  logic                 pop,
    output logic [15:0]          record_word,
    output logic [1:0]           word_bytes,
    output logic                 is_header,
    output logic                 record_last
);
    import sfsc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EMIT
    } state_t;

    logic [15:0] mem [MEM_DEPTH];
    logic [15:0] rd_data_reg;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] off_reg, off_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      word_reg, word_next;
    logic [1:0]       bytes_reg, bytes_next;
    logic             hdr_reg, hdr_next;
    logic             last_reg, last_next;

    logic             out_free;
    logic [CNT_W-1:0] remain;
    logic             two;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.hi_lane)
            begin
                mem[{wr.bank, wr.widx}][15:8] <= wr.data;
            end
            else
            begin
                mem[{wr.bank, wr.widx}][7:0] <= wr.data;
            end
        end
        rd_data_reg <= mem[{rd_bank, WIDX_W'(off_reg >> 1)}];
    end

    assign out_free = !out_valid_reg || pop;
    assign remain   = head.cnt - off_reg;
    assign two      = (remain >= CNT_W'(2));

    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        bytes_next     = bytes_reg;
        hdr_next       = hdr_reg;
        last_next      = last_reg;
        done           = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    out_valid_next = 1'b1;
                    word_next      = head.len;
                    bytes_next     = BYTES_TWO;
                    hdr_next       = 1'b1;
                    last_next      = (head.cnt == '0);
                    off_next       = '0;
                    if (head.cnt == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    word_next      = two ? rd_data_reg : {rd_data_reg[15:8], 8'h00};
                    bytes_next     = two ? BYTES_TWO : BYTES_ONE;
                    hdr_next       = 1'b0;
                    last_next      = (remain <= CNT_W'(2));
                    if (remain <= CNT_W'(2))
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        off_next   = off_reg + CNT_W'(2);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        bytes_reg <= bytes_next;
        hdr_reg   <= hdr_next;
        last_reg  <= last_next;
    end

    assign empty       = !out_valid_reg;
    assign record_word = word_reg;
    assign word_bytes  = bytes_reg;
    assign is_header   = hdr_reg;
    assign record_last = last_reg;

endmodule

// ===== rtl/core/sampled_frame_snap_capture_unit.sv =====
// Top level of the sampled frame snap capture unit.
//
// Frames enter one byte per transaction, each byte with an end-of-frame mark,
// and the input side accepts a byte in every cycle while full is low. At the
// first byte of each frame a countdown reloaded from sample_rate selects one
// frame in sample_rate (a rate of zero or one samples every frame, and the
// first frame after reset is always sampled). For a sampled frame the unit
// counts the length, saturating at 65535, and keeps the first SNAP_BYTES
// bytes in one of two banks of a capture store. When the frame ends, a
// descriptor for the record enters a two-entry queue and the next sampled
// frame fills the other bank, so capture continues while the record drains.
// full rises only while two finished records are still waiting, because
// both banks are then owned by the back end. The back end emits each record
// as a header transaction carrying the length and then big-endian byte pairs,
// the final one marked with record_last; an odd final byte comes with a zero
// low half and word_bytes of one. The header is loaded straight into the
// output register; each data word takes a store read and then a load of the
// output register, and a stalled consumer holds the next load back. The
// sample_rate register is written through cfg_we and cfg_wdata; the user is
// to write it only while the unit is idle, which the unit does not enforce.
// A new rate is only picked up when the countdown next reloads, so frames
// still counted down under the old rate come first.
module sampled_frame_snap_capture_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] record_word,
    output logic [1:0]  word_bytes,
    output logic        is_header,
    output logic        record_last
);
    import sfsc_pkg::*;

    logic       accept;
    sfsc_wr_t   wr;
    logic       desc_push;
    sfsc_desc_t push_desc;
    logic       wr_bank;
    logic       head_valid;
    logic       rd_bank;
    sfsc_desc_t head;
    logic       done;

    assign accept = push && !full;

    // Front end classifies each byte and writes the kept bytes.
    sfsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .bank       (wr_bank),
        .wr         (wr),
        .desc_push  (desc_push),
        .desc       (push_desc)
    );

    // The queue entry index doubles as the bank of the capture store.
    sfsc_desc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (desc_push),
        .push_desc  (push_desc),
        .pop        (done),
        .full       (full),
        .wr_bank    (wr_bank),
        .head_valid (head_valid),
        .rd_bank    (rd_bank),
        .head       (head)
    );

    // Back end walks the oldest record and presents its words.
    sfsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .head_valid  (head_valid),
        .rd_bank     (rd_bank),
        .head        (head),
        .done        (done),
        .empty       (empty),
        .pop         (pop),
        .record_word (record_word),
        .word_bytes  (word_bytes),
        .is_header   (is_header),
        .record_last (record_last)
    );

    // A record always holds at least one data word, so the header is never last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_header) |-> !record_last)
        else $error("header word marked as last");

    // A single-byte word only ends a record and carries a zero low half.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && word_bytes == BYTES_ONE) |-> (record_last && record_word[7:0] == 8'h00))
        else $error("odd word not final or low half not zero");

    // Data words report one or two bytes, and the header always two.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (word_bytes == BYTES_TWO || (word_bytes == BYTES_ONE && !is_header)))
        else $error("bad byte count on record word");

    // The front end never writes the bank that the back end is draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en && head_valid) |-> (wr.bank != rd_bank))
        else $error("capture write into bank being drained");

    // A descriptor is never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> !full)
        else $error("descriptor pushed while queue full");

endmodule

// ===== bench/capture_record_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts capture records from the accepted frame bytes and compares them.
module capture_record_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] record_word,
    input  logic [1:0]  word_bytes,
    input  logic        is_header,
    input  logic        record_last,
    output int          mismatch_count,
    output int          words_outstanding,
    output int          words_checked
);

    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  nbytes;
        logic        header;
        logic        last;
    } record_word_t;

    record_word_t pending_record_words[$];

    logic [15:0] rate_setting;
    logic [15:0] countdown;
    logic [15:0] frame_len;
    logic        mid_frame;
    logic        sampling;
    logic [7:0]  kept_bytes [0:sfsc_pkg::SNAP_BYTES-1];
    int          kept_count;

    // Advances the sampler by one frame byte and queues the record words it completes.
    task automatic absorb_frame_byte(input logic [7:0] b, input logic last_byte);
        record_word_t w;
        int i;
        begin
            if (!mid_frame) begin
                if (countdown > 16'd1) begin
                    countdown = countdown - 16'd1;
                    sampling = 1'b0;
                end
                else begin
                    countdown = rate_setting;
                    sampling = 1'b1;
                    frame_len = 16'd0;
                    kept_count = 0;
                end
            end
            if (sampling) begin
                if (frame_len != sfsc_pkg::LEN_MAX)
                    frame_len = frame_len + 16'd1;
                if (kept_count < sfsc_pkg::SNAP_BYTES) begin
                    kept_bytes[kept_count] = b;
                    kept_count++;
                end
            end
            mid_frame = !last_byte;
            if (last_byte && sampling) begin
                w.word = frame_len;
                w.nbytes = sfsc_pkg::BYTES_TWO;
                w.header = 1'b1;
                w.last = (kept_count == 0);
                pending_record_words.push_back(w);
                i = 0;
                while (i < kept_count) begin
                    w.word = {kept_bytes[i], 8'h00};
                    w.nbytes = sfsc_pkg::BYTES_ONE;
                    w.header = 1'b0;
                    if (kept_count - i >= 2) begin
                        w.word[7:0] = kept_bytes[i + 1];
                        w.nbytes = sfsc_pkg::BYTES_TWO;
                    end
                    i = i + int'(w.nbytes);
                    w.last = (i >= kept_count);
                    pending_record_words.push_back(w);
                end
                sampling = 1'b0;
            end
        end
    endtask

    // Compares one popped record word with the oldest predicted one.
    task automatic match_record_word();
        record_word_t got;
        record_word_t want;
        begin
            got = {record_word, word_bytes, is_header, record_last};
            if (pending_record_words.size() == 0) begin
                if (mismatch_count < 10)
                    $display("capture_record_checker: unexpected word %h bytes %0d hdr %b last %b",
                             got.word, got.nbytes, got.header, got.last);
                mismatch_count++;
            end
            else begin
                want = pending_record_words.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10)
                        $display({"capture_record_checker: mismatch, expected word %h bytes %0d",
                                  " hdr %b last %b, got word %h bytes %0d hdr %b last %b"},
                                 want.word, want.nbytes, want.header, want.last,
                                 got.word, got.nbytes, got.header, got.last);
                    mismatch_count++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rate_setting = sfsc_pkg::RATE_RESET;
            countdown = 16'd1;
            frame_len = 16'd0;
            mid_frame = 1'b0;
            sampling = 1'b0;
            kept_count = 0;
            pending_record_words.delete();
            mismatch_count = 0;
            words_checked = 0;
            words_outstanding = 0;
        end
        else begin
            if (pop && !empty) begin
                match_record_word();
                words_checked++;
            end
            if (push && !full)
                absorb_frame_byte(frame_byte, frame_end);
            if (cfg_we)
                rate_setting = cfg_wdata;
            words_outstanding = pending_record_words.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the capture unit testbench: clock, reset, frame stimulus and the verdict.
module tb_top;

    // The limit sits far above what a correct run needs, even with the long
    // hold-off and the heaviest stalling.
    localparam int CYCLE_LIMIT = 20000;

    // The long frame runs past the snap length so that extra bytes are
    // counted but not kept, and its record has the most words possible.
    localparam int LONG_FRAME_LEN = 66;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  frame_byte = 8'h00;
    logic        frame_end = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [15:0] record_word;
    logic [1:0]  word_bytes;
    logic        is_header;
    logic        record_last;

    int mismatch_count;
    int words_outstanding;
    int words_checked;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct = 0;
    int stall_pct = 0;

    // The receiver pops nothing until the cycle counter reaches hold_until.
    int hold_until = 0;
    int cycle_count = 0;
    int frames_sent = 0;
    int bytes_sent = 0;

    sampled_frame_snap_capture_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .empty       (empty),
        .pop         (pop),
        .record_word (record_word),
        .word_bytes  (word_bytes),
        .is_header   (is_header),
        .record_last (record_last)
    );

    capture_record_checker record_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .frame_byte        (frame_byte),
        .frame_end         (frame_end),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .empty             (empty),
        .pop               (pop),
        .record_word       (record_word),
        .word_bytes        (word_bytes),
        .is_header         (is_header),
        .record_last       (record_last),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding),
        .words_checked     (words_checked)
    );

    always #6 clk = ~clk;

    // The cycle counter doubles as the watchdog for a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // The receiver side runs in its own process. It decides at every falling
    // edge whether to pop in the coming cycle; during a hold-off it refuses all
    // words so that the record queue inside the block fills up.
    always @(negedge clk) begin
        if (!rst_n || cycle_count < hold_until)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= stall_pct);
    end

    // Byte values lean toward the extremes so that every bit sees both levels
    // and the all-zero and all-one pairs show up in the packed words.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Most frames are short; one in ten sits around the snap length so that
    // frames just under, at and just over it are all exercised.
    function automatic int random_frame_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(6, 1);
        else if (r < 90)
            return $urandom_range(40, 7);
        else
            return $urandom_range(67, 61);
    endfunction

    // Offers one byte and returns at the falling edge after it was taken.
    // push stays high between back-to-back bytes and only drops for idle gaps.
    task automatic send_byte(input logic [7:0] b, input logic last_byte);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        frame_byte <= b;
        frame_end <= last_byte;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_random_frame(input int len);
        for (int i = 0; i < len; i++)
            send_byte(random_byte(), i == len - 1);
        frames_sent++;
    endtask

    task automatic send_single_byte_frames(input int count);
        repeat (count)
            send_random_frame(1);
    endtask

    // Waits until every predicted word has been popped, then gives the block
    // time to finish any unsampled frame it may still be chewing on.
    task automatic settle();
        push <= 1'b0;
        while (words_outstanding != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    // The rate register is only written from an idle block.
    task automatic write_rate(input logic [15:0] rate);
        cfg_we <= 1'b1;
        cfg_wdata <= rate;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random phase: frames of random size until the byte budget is spent.
    task automatic random_phase(input logic [15:0] rate, input int idle, input int stall,
                                input int budget);
        int start;
        start = bytes_sent;
        write_rate(rate);
        idle_pct = idle;
        stall_pct = stall;
        while (bytes_sent - start < budget)
            send_random_frame(random_frame_len());
        settle();
    endtask

    initial begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset rate of ten: the very first frame is sampled, the next nine
        // pass unrecorded, and the eleventh is sampled again. The first record
        // is a lone 0xFF (odd final byte), the second an even pair.
        send_byte(8'hFF, 1'b1);
        frames_sent++;
        send_single_byte_frames(9);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        frames_sent++;
        settle();

        // A new rate only applies at the next reload, so the countdown left
        // from the reset rate still has to run out before rate one takes hold.
        write_rate(16'd1);
        send_single_byte_frames(9);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b1);
        frames_sent++;
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);
        frames_sent++;
        settle();

        // A frame longer than the snap buffer; rate one guarantees it is
        // sampled, and its record is a header plus a full set of pairs.
        send_random_frame(LONG_FRAME_LEN);
        settle();

        // Random phases across the idling and stalling mixes. A rate of zero reloads zero,
        // which has to behave like sampling every frame.
        random_phase(16'd0, 0, 0, 6);
        random_phase(16'd2, 54, 0, 6);
        random_phase(16'd1, 0, 54, 6);
        random_phase(16'd3, 12, 12, 6);

        // Back pressure: the receiver refuses everything for a long stretch
        // while the sender keeps pushing sampled frames, so both banks end up
        // owned by waiting records and full has to stall the input.
        write_rate(16'd1);
        idle_pct = 0;
        stall_pct = 0;
        hold_until = cycle_count + 400;
        repeat (6)
            send_random_frame(3);
        settle();

        // Largest rate: one frame is sampled at the reload, the rest pass.
        random_phase(16'hFFFF, 12, 12, 4);

        // Allow a full record drain worth of cycles for any stray output.
        repeat (70) @(negedge clk);

        $display("tb_top: %0d frames, %0d bytes, sample rates 10, 1, 0, 2, 3 and 65535",
                 frames_sent, bytes_sent);
        $display("tb_top: snap limit, rate reload, back pressure and idling covered, %0d words",
                 words_checked);
        if (mismatch_count == 0 && words_outstanding == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
